>>> rtl/hcs_pkg.sv
`timescale 1ns / 1ps

package hcs_pkg;

	localparam int NUM_BINS   = 256;
	localparam int BIN_BITS   = 8;
	localparam int COUNT_BITS = 24;
	localparam int MIN_BITS   = 24;
	localparam int PIX_BITS   = 8;
	localparam int LOW_BITS   = 9;
	// 510*k + d with k, d up to 255
	localparam int NUM_BITS   = 17;
	localparam int DIV_STEPS  = BIN_BITS;
	localparam int PHASE_BITS = $clog2(DIV_STEPS + 1);
	localparam int CMP_BITS   = (COUNT_BITS > MIN_BITS) ? COUNT_BITS : MIN_BITS;

	localparam logic REQ_HIST = 1'b0;
	localparam logic REQ_MAP  = 1'b1;

	localparam logic KIND_BOUNDS = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_DRAIN,
		ST_SCAN,
		ST_BUILD,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic hist_acc;
		logic map_acc;
		logic scan_start;
		logic scan_step;
		logic build_start;
		logic build_step;
		logic load_report;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic build_done;
		logic out_valid;
	} status_t;

endpackage

>>> rtl/hcs_if.sv
`timescale 1ns / 1ps

interface hcs_in_if;
	import hcs_pkg::*;

	logic                valid;
	logic                ready;
	logic                req_type;
	logic [PIX_BITS-1:0] pixel_in;
	logic                frame_last;

	modport source (output valid, output req_type, output pixel_in, output frame_last,
		input ready);
	modport sink (input valid, input req_type, input pixel_in, input frame_last,
		output ready);
endinterface

interface hcs_out_if;
	import hcs_pkg::*;

	logic                valid;
	logic                ready;
	logic                result_kind;
	logic [PIX_BITS-1:0] pixel_out;
	logic [LOW_BITS-1:0] low_bin;
	logic [BIN_BITS-1:0] high_bin;

	modport source (output valid, output result_kind, output pixel_out, output low_bin,
		output high_bin, input ready);
	modport sink (input valid, input result_kind, input pixel_out, input low_bin,
		input high_bin, output ready);
endinterface

interface hcs_cfg_if;
	import hcs_pkg::*;

	logic                valid;
	logic                ready;
	logic [MIN_BITS-1:0] min_count;

	modport source (output valid, output min_count, input ready);
	modport sink (input valid, input min_count, output ready);
endinterface

>>> rtl/hcs_ctrl.sv
`timescale 1ns / 1ps

module hcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_req_type,
	input  logic              in_frame_last,
	output logic              in_ready,
	input  logic              out_ready,
	input  hcs_pkg::status_t  stat,
	output hcs_pkg::cmd_t     cmd
);
	import hcs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_free;
	logic   accept;

	assign out_free = !stat.out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (accept && in_req_type == REQ_HIST && in_frame_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_BUILD;
				end
			end
			ST_BUILD: begin
				if (stat.build_done) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_RUN: begin
				in_ready     = out_free;
				cmd.hist_acc = accept && in_req_type == REQ_HIST;
				cmd.map_acc  = accept && in_req_type == REQ_MAP;
			end
			ST_DRAIN: begin
				// last increment lands at the end of this cycle
				cmd.scan_start = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan_step   = 1'b1;
				cmd.build_start = stat.scan_done;
			end
			ST_BUILD: begin
				cmd.build_step = 1'b1;
			end
			ST_REPORT: begin
				cmd.load_report = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/hcs_datapath.sv
`timescale 1ns / 1ps

module hcs_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hcs_pkg::cmd_t                cmd,
	output hcs_pkg::status_t             stat,
	input  logic [hcs_pkg::PIX_BITS-1:0] pixel_in,
	input  logic                         cfg_wr,
	input  logic [hcs_pkg::MIN_BITS-1:0] cfg_min_count,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic                         result_kind,
	output logic [hcs_pkg::PIX_BITS-1:0] pixel_out,
	output logic [hcs_pkg::LOW_BITS-1:0] low_bin,
	output logic [hcs_pkg::BIN_BITS-1:0] high_bin
);
	import hcs_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [MIN_BITS-1:0]   min_count_q;

	// bin counter memory, entries without a valid flag read as zero
	logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
	logic [NUM_BINS-1:0]   bin_vld_q;
	logic                  rd_en;
	logic [BIN_BITS-1:0]   rd_addr;
	logic [COUNT_BITS-1:0] rd_data_q;
	logic                  rd_vld_q;
	logic [COUNT_BITS-1:0] rd_count;

	logic                  inc_vld_s1;
	logic [BIN_BITS-1:0]   inc_addr_s1;
	logic                  wr_vld_s2;
	logic [BIN_BITS-1:0]   wr_addr_s2;
	logic [COUNT_BITS-1:0] wr_data_s2;
	logic [COUNT_BITS-1:0] inc_cur;
	logic [COUNT_BITS-1:0] inc_new;

	logic [BIN_BITS:0]     scan_cnt_q;
	logic                  scan_rd;
	logic                  scan_vld_s1;
	logic [BIN_BITS-1:0]   scan_addr_s1;
	logic                  scan_hit;
	logic [LOW_BITS-1:0]   lo_q;
	logic [BIN_BITS-1:0]   hi_q;

	logic [PIX_BITS-1:0]   map_mem [NUM_BINS];
	logic                  built_q;

	logic [BIN_BITS:0]     bld_v_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [NUM_BITS-1:0]   rem_q;
	logic [PIX_BITS-1:0]   quo_q;
	logic                  bld_active;
	logic [BIN_BITS-1:0]   bld_v8;
	logic                  bld_below;
	logic                  bld_above;
	logic [BIN_BITS-1:0]   bld_d;
	logic [BIN_BITS-1:0]   bld_k;
	logic                  bld_special;
	logic [NUM_BITS-1:0]   bld_num;
	logic [$clog2(DIV_STEPS)-1:0] bit_i;
	logic [NUM_BITS-1:0]   div_sh;
	logic                  div_take;
	logic [NUM_BITS-1:0]   rem_nxt;
	logic [PIX_BITS-1:0]   quo_nxt;
	logic                  bld_wr;
	logic [PIX_BITS-1:0]   bld_data;

	logic                  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_count_q <= '0;
		end else if (cfg_wr) begin
			min_count_q <= cfg_min_count;
		end
	end

	// ---- bin memory read port: pixel increments or scan ----
	assign scan_rd = cmd.scan_step && !scan_cnt_q[BIN_BITS];
	assign rd_en   = cmd.hist_acc || scan_rd;
	assign rd_addr = cmd.hist_acc ? pixel_in : scan_cnt_q[BIN_BITS-1:0];
	assign rd_count = rd_vld_q ? rd_data_q : '0;

	// forward the write that landed at the same edge as this read
	assign inc_cur = (wr_vld_s2 && wr_addr_s2 == inc_addr_s1) ? wr_data_s2 : rd_count;
	assign inc_new = (inc_cur == COUNT_MAX) ? inc_cur : inc_cur + 1'b1;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= bin_mem[rd_addr];
			rd_vld_q  <= bin_vld_q[rd_addr];
		end
		if (inc_vld_s1) begin
			bin_mem[inc_addr_s1] <= inc_new;
		end
		inc_addr_s1  <= pixel_in;
		wr_addr_s2   <= inc_addr_s1;
		wr_data_s2   <= inc_new;
		scan_addr_s1 <= scan_cnt_q[BIN_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q   <= '0;
			inc_vld_s1  <= 1'b0;
			wr_vld_s2   <= 1'b0;
			scan_vld_s1 <= 1'b0;
		end else begin
			inc_vld_s1  <= cmd.hist_acc;
			wr_vld_s2   <= inc_vld_s1;
			scan_vld_s1 <= scan_rd;
			if (cmd.build_start) begin
				bin_vld_q <= '0;
			end else if (inc_vld_s1) begin
				bin_vld_q[inc_addr_s1] <= 1'b1;
			end
		end
	end

	// ---- bounds scan: one ascending pass finds both ends ----
	assign scan_hit = scan_vld_s1 && (CMP_BITS'(rd_count) > CMP_BITS'(min_count_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			lo_q       <= '0;
			hi_q       <= '1;
		end else if (cmd.scan_start) begin
			scan_cnt_q <= '0;
			lo_q       <= LOW_BITS'(NUM_BINS);
			hi_q       <= '0;
		end else begin
			if (scan_rd) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (scan_hit) begin
				if (lo_q[BIN_BITS]) begin
					lo_q <= {1'b0, scan_addr_s1};
				end
				// a hit on bin zero never moves the high bound
				if (scan_addr_s1 != '0) begin
					hi_q <= scan_addr_s1;
				end
			end
		end
	end

	// ---- table rebuild: restoring divide, one quotient bit a cycle ----
	assign bld_active = cmd.build_step && !bld_v_q[BIN_BITS];
	assign bld_v8     = bld_v_q[BIN_BITS-1:0];
	assign bld_below  = {1'b0, bld_v8} < lo_q;
	assign bld_above  = bld_v8 > hi_q;
	assign bld_d      = hi_q - lo_q[BIN_BITS-1:0];
	assign bld_k      = bld_v8 - lo_q[BIN_BITS-1:0];
	assign bld_special = bld_below || bld_above || bld_d == '0;
	// 510*k + d
	assign bld_num    = {bld_k, 9'b0} - {8'b0, bld_k, 1'b0} + {9'b0, bld_d};
	assign bit_i      = ($clog2(DIV_STEPS))'(PHASE_BITS'(DIV_STEPS) - phase_q);
	assign div_sh     = {8'b0, bld_d, 1'b0} << bit_i;
	assign div_take   = rem_q >= div_sh;
	assign rem_nxt    = div_take ? rem_q - div_sh : rem_q;
	assign quo_nxt    = quo_q | (div_take ? (PIX_BITS'(1) << bit_i) : '0);

	always_comb begin
		bld_wr   = 1'b0;
		bld_data = '0;
		if (phase_q == '0) begin
			bld_wr   = bld_active && bld_special;
			bld_data = (bld_above && !bld_below) ? '1 : '0;
		end else begin
			bld_wr   = bld_active && phase_q == PHASE_BITS'(DIV_STEPS);
			bld_data = quo_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bld_v_q <= '0;
			phase_q <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			built_q <= 1'b0;
		end else if (cmd.build_start) begin
			bld_v_q <= '0;
			phase_q <= '0;
			built_q <= 1'b1;
		end else if (bld_active) begin
			if (phase_q == '0) begin
				if (bld_special) begin
					bld_v_q <= bld_v_q + 1'b1;
				end else begin
					rem_q   <= bld_num;
					quo_q   <= '0;
					phase_q <= PHASE_BITS'(1);
				end
			end else begin
				rem_q <= rem_nxt;
				quo_q <= quo_nxt;
				if (phase_q == PHASE_BITS'(DIV_STEPS)) begin
					phase_q <= '0;
					bld_v_q <= bld_v_q + 1'b1;
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
		end
	end

	// ---- map table, read straight into the output register ----
	always_ff @(posedge clk) begin
		if (bld_wr) begin
			map_mem[bld_v8] <= bld_data;
		end
		if (cmd.map_acc) begin
			result_kind <= KIND_PIXEL;
			pixel_out   <= built_q ? map_mem[pixel_in] : pixel_in;
			low_bin     <= '0;
			high_bin    <= '0;
		end else if (cmd.load_report) begin
			result_kind <= KIND_BOUNDS;
			pixel_out   <= '0;
			low_bin     <= lo_q;
			high_bin    <= hi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.map_acc || cmd.load_report) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign stat.out_valid  = out_valid_q;
	assign stat.scan_done  = scan_cnt_q[BIN_BITS] && !scan_vld_s1;
	assign stat.build_done = bld_v_q[BIN_BITS];

endmodule

>>> rtl/histogram_contrast_stretch_core.sv
`timescale 1ns / 1ps

// Histogram contrast stretch for 8-bit grey pixels. Histogram and map
// requests are taken one per clock while the result register drains; a
// histogram request bumps a saturating bin in a 256-entry counter memory
// (registered read, then write, with forwarding for repeated values), a
// map request returns its stretched value the next cycle. A histogram
// request flagged frame_last stops intake: its increment completes, all
// bins are scanned through the single memory read port for the low and
// high bounds, then the table is rebuilt, entries outside the bounds (or
// every entry when the bounds meet) written directly and each one inside
// through the divider, one quotient bit a cycle; then the bounds report
// is presented and intake resumes. No clearing pass is needed after
// reset: bins carry valid flags and the table reads as identity until
// the first rebuild. min_count may be written at any time the block is
// idle.
module histogram_contrast_stretch_core (
	input  logic clk,
	input  logic arst_n,
	hcs_in_if.sink    pixels,
	hcs_out_if.source results,
	hcs_cfg_if.sink   cfg
);
	import hcs_pkg::*;

	cmd_t    cmd;
	status_t stat;

	assign cfg.ready = 1'b1;

	hcs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (pixels.valid),
		.in_req_type   (pixels.req_type),
		.in_frame_last (pixels.frame_last),
		.in_ready      (pixels.ready),
		.out_ready     (results.ready),
		.stat          (stat),
		.cmd           (cmd)
	);

	hcs_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.pixel_in      (pixels.pixel_in),
		.cfg_wr        (cfg.valid && cfg.ready),
		.cfg_min_count (cfg.min_count),
		.out_ready     (results.ready),
		.out_valid     (results.valid),
		.result_kind   (results.result_kind),
		.pixel_out     (results.pixel_out),
		.low_bin       (results.low_bin),
		.high_bin      (results.high_bin)
	);

endmodule

>>> tb/tb_histogram_contrast_stretch_core.sv
`timescale 1ns / 1ps

module tb_histogram_contrast_stretch_core;
	import hcs_pkg::*;

	localparam int                    STALL_LIMIT = 20000;
	localparam int                    HOLD_CYCLES = 300;
	// a plain histogram request still has its read and write stages to finish after intake
	localparam int                    SETTLE      = 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
	localparam logic [MIN_BITS-1:0]   MIN_ALL     = '1;

	typedef struct packed {
		logic                kind;
		logic [PIX_BITS-1:0] pix;
		logic [LOW_BITS-1:0] low;
		logic [BIN_BITS-1:0] high;
	} stretch_out_t;

	logic clk;
	logic arst_n;

	hcs_in_if  pixels_if ();
	hcs_out_if results_if ();
	hcs_cfg_if cfg_if ();

	histogram_contrast_stretch_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pixels_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	// predictor state
	logic [COUNT_BITS-1:0] bin_cnt [NUM_BINS];
	logic [PIX_BITS-1:0]   map_lut [NUM_BINS];
	logic [MIN_BITS-1:0]   min_cnt;
	stretch_out_t          stretch_due [$];

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_req;
	int hold_left;
	int longest_hold;
	int requests_sent;
	int pixels_seen;
	int reports_seen;
	int cfg_writes;
	int mismatches;
	int quiet_cycles;

	always #5 clk = ~clk;

	// map lookup, bins, bounds search, table rebuild
	function automatic void stretch_predict(logic kind, logic [PIX_BITS-1:0] pix, logic last);
		stretch_out_t r;
		int lo;
		int hi;
		int d;
		int e;
		if (kind == REQ_MAP) begin
			r.kind = KIND_PIXEL;
			r.pix  = map_lut[pix];
			r.low  = '0;
			r.high = '0;
			stretch_due.push_back(r);
			return;
		end
		if (bin_cnt[pix] != COUNT_MAX)
			bin_cnt[pix]++;
		if (!last)
			return;
		lo = 0;
		hi = NUM_BINS - 1;
		while (lo < NUM_BINS && bin_cnt[lo] <= min_cnt)
			lo++;
		while (hi > 0 && bin_cnt[hi] <= min_cnt)
			hi--;
		for (int v = 0; v < NUM_BINS; v++) begin
			if (v < lo)
				e = 0;
			else if (v > hi)
				e = 255;
			else if (hi == lo)
				e = 0;
			else begin
				d = hi - lo;
				e = (510 * (v - lo) + d) / (2 * d);
				if (e > 255)
					e = 255;
			end
			map_lut[v] = e[PIX_BITS-1:0];
			bin_cnt[v] = '0;
		end
		r.kind = KIND_BOUNDS;
		r.pix  = '0;
		r.low  = lo[LOW_BITS-1:0];
		r.high = hi[BIN_BITS-1:0];
		stretch_due.push_back(r);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// receiver: result check, random stall, long hold-off on request
	always @(posedge clk) begin
		stretch_out_t want;
		if (hold_req != 0) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 0;
		end
		if (results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			if (stretch_due.size() == 0)
				report_mismatch("unexpected result, kind", results_if.result_kind, 0);
			else begin
				want = stretch_due.pop_front();
				if (results_if.result_kind !== want.kind)
					report_mismatch("result_kind", results_if.result_kind, want.kind);
				else if (want.kind == KIND_PIXEL)
					pixels_seen++;
				else
					reports_seen++;
				if (results_if.pixel_out !== want.pix)
					report_mismatch("pixel_out", results_if.pixel_out, want.pix);
				if (results_if.low_bin !== want.low)
					report_mismatch("low_bin", results_if.low_bin, want.low);
				if (results_if.high_bin !== want.high)
					report_mismatch("high_bin", results_if.high_bin, want.high);
			end
		end
		if (hold_left > 0) begin
			results_if.ready <= 1'b0;
			hold_left--;
			if (HOLD_CYCLES - hold_left > longest_hold)
				longest_hold = HOLD_CYCLES - hold_left;
		end else begin
			results_if.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((pixels_if.valid && pixels_if.ready) || (results_if.valid && results_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d results outstanding",
				STALL_LIMIT, stretch_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_pixel(logic kind, logic [PIX_BITS-1:0] pix, logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			pixels_if.valid <= 1'b0;
			@(posedge clk);
		end
		pixels_if.valid      <= 1'b1;
		pixels_if.req_type   <= kind;
		pixels_if.pixel_in   <= pix;
		pixels_if.frame_last <= last;
		@(posedge clk);
		while (pixels_if.ready !== 1'b1)
			@(posedge clk);
		stretch_predict(kind, pix, last);
		requests_sent++;
	endtask

	// must be called in the step of the last acceptance
	task automatic drain_results();
		pixels_if.valid <= 1'b0;
		while (stretch_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_min_count(logic [MIN_BITS-1:0] value);
		drain_results();
		cfg_if.valid     <= 1'b1;
		cfg_if.min_count <= value;
		@(posedge clk);
		while (cfg_if.ready !== 1'b1)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		min_cnt = value;
		cfg_writes++;
	endtask

	task automatic test_reset_identity();
		send_pixel(REQ_MAP, 8'd0, 1'b0);
		send_pixel(REQ_MAP, 8'd255, 1'b0);
		send_pixel(REQ_MAP, 8'd170, 1'b0);
		// frame mark is ignored on map requests
		send_pixel(REQ_MAP, 8'd85, 1'b1);
	endtask

	task automatic test_two_bin_frame();
		send_pixel(REQ_HIST, 8'd10, 1'b0);
		send_pixel(REQ_HIST, 8'd10, 1'b0);
		send_pixel(REQ_HIST, 8'd200, 1'b1);
		send_pixel(REQ_MAP, 8'd9, 1'b0);
		send_pixel(REQ_MAP, 8'd10, 1'b0);
		send_pixel(REQ_MAP, 8'd105, 1'b0);
		send_pixel(REQ_MAP, 8'd200, 1'b0);
		send_pixel(REQ_MAP, 8'd201, 1'b0);
	endtask

	// low == high: whole table collapses to a step
	task automatic test_single_bin_frame();
		send_pixel(REQ_HIST, 8'd77, 1'b1);
		send_pixel(REQ_MAP, 8'd76, 1'b0);
		send_pixel(REQ_MAP, 8'd77, 1'b0);
		send_pixel(REQ_MAP, 8'd78, 1'b0);
	endtask

	task automatic test_threshold_extremes();
		// nothing qualifies: low 256, high 0
		set_min_count(MIN_ALL);
		send_pixel(REQ_HIST, 8'd0, 1'b0);
		send_pixel(REQ_HIST, 8'd255, 1'b1);
		send_pixel(REQ_MAP, 8'd128, 1'b0);
		// singles drop out, full-range bounds from the doubled ends
		set_min_count(24'd1);
		send_pixel(REQ_HIST, 8'd0, 1'b0);
		send_pixel(REQ_HIST, 8'd255, 1'b0);
		send_pixel(REQ_HIST, 8'd0, 1'b0);
		send_pixel(REQ_HIST, 8'd255, 1'b0);
		send_pixel(REQ_HIST, 8'd3, 1'b1);
		send_pixel(REQ_MAP, 8'd3, 1'b0);
		send_pixel(REQ_MAP, 8'd128, 1'b0);
	endtask

	// output held off while input keeps coming; block must back up and stall
	task automatic test_back_pressure();
		hold_req = 1;
		for (int i = 0; i < 30; i++)
			send_pixel(REQ_MAP, 8'($urandom_range(255)), 1'($urandom_range(1)));
		send_pixel(REQ_HIST, 8'd40, 1'b0);
		send_pixel(REQ_HIST, 8'd90, 1'b1);
		for (int i = 0; i < 10; i++)
			send_pixel(REQ_MAP, 8'($urandom_range(255)), 1'b0);
	endtask

	// frames clustered around a center, with stray values and interleaved map requests
	task automatic test_random_frames(int count);
		int target;
		int center;
		int spread;
		int nhist;
		int nmap;
		int p;
		logic last;
		target = requests_sent + count;
		while (requests_sent < target) begin
			center = $urandom_range(255);
			spread = $urandom_range(100);
			nhist  = $urandom_range(40, 1);
			nmap   = $urandom_range(25);
			for (int i = 0; i < nhist; i++) begin
				if ($urandom_range(99) < 15)
					send_pixel(REQ_MAP, 8'($urandom_range(255)), 1'($urandom_range(1)));
				if ($urandom_range(99) < 10)
					p = $urandom_range(255);
				else
					p = center + int'($urandom_range(2 * spread)) - spread;
				if (p < 0)
					p = 0;
				if (p > 255)
					p = 255;
				// now and then a frame runs on without its end mark
				last = (i == nhist - 1) && ($urandom_range(99) >= 5);
				send_pixel(REQ_HIST, p[PIX_BITS-1:0], last);
			end
			for (int i = 0; i < nmap; i++)
				send_pixel(REQ_MAP, 8'($urandom_range(255)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		logic [MIN_BITS-1:0] thresholds [6];
		thresholds = '{24'd0, 24'd2, 24'd1, MIN_ALL, 24'd3, 24'd0};
		clk                  = 1'b0;
		arst_n               = 1'b0;
		pixels_if.valid      = 1'b0;
		pixels_if.req_type   = REQ_HIST;
		pixels_if.pixel_in   = '0;
		pixels_if.frame_last = 1'b0;
		results_if.ready     = 1'b0;
		cfg_if.valid         = 1'b0;
		cfg_if.min_count     = '0;
		hold_req             = 0;
		hold_left            = 0;
		longest_hold         = 0;
		requests_sent        = 0;
		pixels_seen          = 0;
		reports_seen         = 0;
		cfg_writes           = 0;
		mismatches           = 0;
		quiet_cycles         = 0;
		min_cnt              = '0;
		for (int v = 0; v < NUM_BINS; v++) begin
			bin_cnt[v] = '0;
			map_lut[v] = v[PIX_BITS-1:0];
		end
		tx_idle_pct = 22;
		rx_idle_pct = 59;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_identity();
		test_two_bin_frame();
		test_single_bin_frame();
		test_threshold_extremes();
		test_back_pressure();

		for (int ph = 0; ph < 6; ph++) begin
			tx_idle_pct = (ph < 2) ? 22 : (ph < 4) ? 59 : 0;
			rx_idle_pct = (ph < 2) ? 59 : (ph < 4) ? 22 : 0;
			set_min_count(thresholds[ph]);
			test_random_frames(160);
		end

		drain_results();
		while (stretch_due.size() != 0) begin
			report_mismatch("result never arrived, kind", 0, stretch_due[0].kind);
			void'(stretch_due.pop_front());
		end
		$display("covered %0d requests: %0d stretched pixels, %0d frame reports, %0d threshold writes",
			requests_sent, pixels_seen, reports_seen, cfg_writes);
		$display("output held off for %0d cycles at most, %0d mismatches", longest_hold, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> histogram_contrast_stretch_core.f
rtl/hcs_pkg.sv
rtl/hcs_if.sv
rtl/hcs_ctrl.sv
rtl/hcs_datapath.sv
rtl/histogram_contrast_stretch_core.sv
tb/tb_histogram_contrast_stretch_core.sv
